[hw/rtl/prr_pkg.sv]
package prr_pkg;

  parameter int unsigned FRAC_BITS  = 16;
  parameter int unsigned POSE_WORDS = 12;
  parameter int unsigned QUO_BITS   = 32;
  parameter int unsigned DEN_BITS   = 33;

  typedef enum logic [1:0] {
    CFG_FOCAL_X  = 2'd0,
    CFG_FOCAL_Y  = 2'd1,
    CFG_CENTER_X = 2'd2,
    CFG_CENTER_Y = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    FUNC_LOAD    = 1'b0,
    FUNC_PROJECT = 1'b1
  } func_e;

  typedef struct packed {
    logic signed [31:0] obs_x;
    logic signed [31:0] obs_y;
    logic               invalid;
    logic               clip;
    logic               neg_x;
    logic               neg_y;
    logic               big_x;
    logic               big_y;
  } side_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r.clip = 1'b1;
      r.val  = 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      r.clip = 1'b1;
      r.val  = 32'sh8000_0000;
    end else begin
      r.clip = 1'b0;
      r.val  = v[31:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/prr_if.sv]
interface prr_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [3:0]         word_index;
  logic signed [31:0] word_value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [31:0] pixel_obs_x;
  logic signed [31:0] pixel_obs_y;

  modport source (output valid, func, word_index, word_value, point_x, point_y, point_z,
                  pixel_obs_x, pixel_obs_y, input ready);
  modport sink (input valid, func, word_index, word_value, point_x, point_y, point_z,
                pixel_obs_x, pixel_obs_y, output ready);
endinterface

interface prr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] residual_x;
  logic signed [31:0] residual_y;
  logic               depth_invalid;
  logic               saturated;

  modport source (output valid, residual_x, residual_y, depth_invalid, saturated,
                  input ready);
  modport sink (input valid, residual_x, residual_y, depth_invalid, saturated,
                output ready);
endinterface

interface prr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/pinhole_reprojection_residual.sv]
// Pinhole reprojection residual in signed fixed point.
// The sink channel in_i carries two kinds of transaction. A load (func 0) writes one pose
// word (rotation row-major in words 0 to 8, translation in 9 to 11) and gives no result;
// a later project transaction sees the new word. A project (func 1) transforms the point
// by the pose, divides by depth, applies focal lengths and principal point and returns
// one result on out_o: the two residuals, a zero-depth flag and a saturation flag.
// Focal lengths and principal point are written through cfg_i; the user must write them only
// while the block is idle, which the block itself does not enforce; cfg_i is always ready.
// A project transaction passes through 38 register stages before its result appears on out_o:
// one product stage, one sum stage, one divide set-up stage, 32 stages of the
// one-bit-per-stage long divider, one normalise stage, one focal product stage and the
// output register. One transaction is accepted every cycle while out_o does not stall.
// Each stage has its own valid bit and moves when the stage after it is empty or moving,
// so a stall on out_o fills the pipeline before in_i drops ready; nothing is lost.
// Reset clears the pose to zero, the focal lengths to one and the principal point to zero.
module pinhole_reprojection_residual
  import prr_pkg::*;
#(
  parameter int unsigned FracBits = FRAC_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  prr_in_if.sink        in_i,
  prr_cfg_if.sink       cfg_i,
  prr_out_if.source     out_o
);

  localparam int unsigned NW = FracBits + DEN_BITS;
  localparam logic signed [63:0] Half = 64'sd1 <<< (FracBits - 1);

  logic signed [31:0] pose_q [POSE_WORDS];
  logic [30:0]        focal_x_q;
  logic [30:0]        focal_y_q;
  logic signed [31:0] center_x_q;
  logic signed [31:0] center_y_q;

  logic rdy_a;
  logic rdy_b;
  logic rdy_c;
  logic rdy_e;
  logic rdy_f;
  logic rdy_g;
  logic div_ready;
  logic div_valid;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= 31'd65536;
      focal_y_q  <= 31'd65536;
      center_x_q <= '0;
      center_y_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_FOCAL_X:  focal_x_q  <= cfg_i.data[30:0];
        CFG_FOCAL_Y:  focal_y_q  <= cfg_i.data[30:0];
        CFG_CENTER_X: center_x_q <= cfg_i.data;
        CFG_CENTER_Y: center_y_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  logic in_acc;
  assign in_acc      = in_i.valid && in_i.ready;
  assign in_i.ready  = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < POSE_WORDS; w++) begin
        pose_q[w] <= '0;
      end
    end else if (in_acc && func_e'(in_i.func) == FUNC_LOAD
                 && in_i.word_index < 4'(POSE_WORDS)) begin
      pose_q[in_i.word_index] <= in_i.word_value;
    end
  end

  // Stage A: the nine rotation products.
  logic               a_v_q;
  logic signed [63:0] a_prod_q [3][3];
  logic signed [31:0] a_t_q    [3];
  logic signed [31:0] a_obs_x_q;
  logic signed [31:0] a_obs_y_q;
  logic signed [31:0] pt [3];

  assign pt[0] = in_i.point_x;
  assign pt[1] = in_i.point_y;
  assign pt[2] = in_i.point_z;
  assign rdy_a = !a_v_q || rdy_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (rdy_a) begin
      a_v_q <= in_i.valid && func_e'(in_i.func) == FUNC_PROJECT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          a_prod_q[i][j] <= 64'(pose_q[3*i+j]) * 64'(pt[j]);
        end
        a_t_q[i] <= pose_q[9+i];
      end
      a_obs_x_q <= in_i.pixel_obs_x;
      a_obs_y_q <= in_i.pixel_obs_y;
    end
  end

  // Stage B: rounded sums give the camera coordinates.
  logic               b_v_q;
  logic signed [31:0] b_cam_q [3];
  logic               b_clip_q;
  logic signed [31:0] b_obs_x_q;
  logic signed [31:0] b_obs_y_q;
  sat_t               b_sat [3];
  logic signed [65:0] b_sum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b_sum[i] = 66'(a_t_q[i]);
      for (int j = 0; j < 3; j++) begin
        b_sum[i] = b_sum[i] + 66'((a_prod_q[i][j] + Half) >>> FracBits);
      end
      b_sat[i] = sat32(b_sum[i]);
    end
  end

  assign rdy_b = !b_v_q || rdy_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (rdy_b) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b) begin
      for (int i = 0; i < 3; i++) begin
        b_cam_q[i] <= b_sat[i].val;
      end
      b_clip_q  <= b_sat[0].clip | b_sat[1].clip | b_sat[2].clip;
      b_obs_x_q <= a_obs_x_q;
      b_obs_y_q <= a_obs_y_q;
    end
  end

  // Stage C: magnitudes and divider operands. The quotient is
  // floor((2n + d) / 2d), which rounds n / d to nearest with ties away from zero.
  logic                c_v_q;
  logic [NW-1:0]       c_num_x_q;
  logic [NW-1:0]       c_num_y_q;
  logic [DEN_BITS-1:0] c_den_q;
  side_t               c_side_q;
  logic [31:0]         mag_x;
  logic [31:0]         mag_y;
  logic [31:0]         mag_z;
  logic [NW-1:0]       num_x;
  logic [NW-1:0]       num_y;
  logic [DEN_BITS-1:0] den;
  side_t               c_side_d;

  always_comb begin
    mag_x = b_cam_q[0][31] ? 32'(-b_cam_q[0]) : 32'(b_cam_q[0]);
    mag_y = b_cam_q[1][31] ? 32'(-b_cam_q[1]) : 32'(b_cam_q[1]);
    mag_z = b_cam_q[2][31] ? 32'(-b_cam_q[2]) : 32'(b_cam_q[2]);
    den   = {mag_z, 1'b0};
    num_x = (NW'(mag_x) << (FracBits + 1)) + NW'(mag_z);
    num_y = (NW'(mag_y) << (FracBits + 1)) + NW'(mag_z);
    c_side_d.obs_x   = b_obs_x_q;
    c_side_d.obs_y   = b_obs_y_q;
    c_side_d.invalid = b_cam_q[2] == '0;
    c_side_d.clip    = b_clip_q;
    c_side_d.neg_x   = b_cam_q[0][31] ^ b_cam_q[2][31];
    c_side_d.neg_y   = b_cam_q[1][31] ^ b_cam_q[2][31];
    c_side_d.big_x   = (num_x >> QUO_BITS) >= NW'(den);
    c_side_d.big_y   = (num_y >> QUO_BITS) >= NW'(den);
  end

  assign rdy_c = !c_v_q || div_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (rdy_c) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c) begin
      c_num_x_q <= num_x;
      c_num_y_q <= num_y;
      c_den_q   <= den;
      c_side_q  <= c_side_d;
    end
  end

  logic [QUO_BITS-1:0] quo_x;
  logic [QUO_BITS-1:0] quo_y;
  side_t               d_side;

  prr_div #(
    .FracBits (FracBits)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_v_q),
    .ready_o (div_ready),
    .num_x_i (c_num_x_q),
    .num_y_i (c_num_y_q),
    .den_i   (c_den_q),
    .side_i  (c_side_q),
    .valid_o (div_valid),
    .ready_i (rdy_e),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y),
    .side_o  (d_side)
  );

  // Stage E: sign and saturation of the normalised coordinates.
  logic               e_v_q;
  logic signed [31:0] e_nrm_x_q;
  logic signed [31:0] e_nrm_y_q;
  side_t              e_side_q;
  sat_t               nrm_x;
  sat_t               nrm_y;
  side_t              e_side_d;

  function automatic sat_t apply_sign(input logic [31:0] q, input logic neg, input logic big);
    sat_t r;
    if (big) begin
      r.clip = 1'b1;
      r.val  = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (neg) begin
      r.clip = q > 32'h8000_0000;
      r.val  = r.clip ? 32'sh8000_0000 : 32'(-q);
    end else begin
      r.clip = q[31];
      r.val  = r.clip ? 32'sh7FFF_FFFF : q;
    end
    return r;
  endfunction

  always_comb begin
    nrm_x         = apply_sign(quo_x, d_side.neg_x, d_side.big_x);
    nrm_y         = apply_sign(quo_y, d_side.neg_y, d_side.big_y);
    e_side_d      = d_side;
    e_side_d.clip = d_side.clip | (!d_side.invalid & (nrm_x.clip | nrm_y.clip));
  end

  assign rdy_e = !e_v_q || rdy_f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (rdy_e) begin
      e_v_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_e) begin
      e_nrm_x_q <= nrm_x.val;
      e_nrm_y_q <= nrm_y.val;
      e_side_q  <= e_side_d;
    end
  end

  // Stage F: focal products.
  logic               f_v_q;
  logic signed [63:0] f_prod_x_q;
  logic signed [63:0] f_prod_y_q;
  side_t              f_side_q;

  assign rdy_f = !f_v_q || rdy_g;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (rdy_f) begin
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_f) begin
      f_prod_x_q <= 64'($signed({1'b0, focal_x_q})) * 64'(e_nrm_x_q);
      f_prod_y_q <= 64'($signed({1'b0, focal_y_q})) * 64'(e_nrm_y_q);
      f_side_q   <= e_side_q;
    end
  end

  // Stage G: round, add the principal point, subtract the observation; zero depth gives zero residuals.
  logic               g_v_q;
  logic signed [31:0] g_res_x_q;
  logic signed [31:0] g_res_y_q;
  logic               g_inv_q;
  logic               g_sat_q;
  sat_t               res_x;
  sat_t               res_y;

  always_comb begin
    res_x = sat32(66'((f_prod_x_q + Half) >>> FracBits) + 66'(center_x_q)
                  - 66'(f_side_q.obs_x));
    res_y = sat32(66'((f_prod_y_q + Half) >>> FracBits) + 66'(center_y_q)
                  - 66'(f_side_q.obs_y));
  end

  assign rdy_g = !g_v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
    end else if (rdy_g) begin
      g_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_g) begin
      g_inv_q <= f_side_q.invalid;
      if (f_side_q.invalid) begin
        g_res_x_q <= '0;
        g_res_y_q <= '0;
        g_sat_q   <= f_side_q.clip;
      end else begin
        g_res_x_q <= res_x.val;
        g_res_y_q <= res_y.val;
        g_sat_q   <= f_side_q.clip | res_x.clip | res_y.clip;
      end
    end
  end

  assign out_o.valid         = g_v_q;
  assign out_o.residual_x    = g_res_x_q;
  assign out_o.residual_y    = g_res_y_q;
  assign out_o.depth_invalid = g_inv_q;
  assign out_o.saturated     = g_sat_q;

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.depth_invalid |-> out_o.residual_x == '0 && out_o.residual_y == '0)
    else $error("zero depth result carries nonzero residuals");
  a_pose_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && func_e'(in_i.func) == FUNC_LOAD && in_i.word_index == 4'd0
    |=> pose_q[0] == $past(in_i.word_value))
    else $error("pose word load was not stored");
  a_blocked_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> a_v_q && b_v_q) else $error("input blocked with free front stages");
`endif

endmodule

[hw/rtl/prr_div.sv]
module prr_div
  import prr_pkg::*;
#(
  parameter int unsigned FracBits = FRAC_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic [FracBits+DEN_BITS-1:0]         num_x_i,
  input  logic [FracBits+DEN_BITS-1:0]         num_y_i,
  input  logic [DEN_BITS-1:0]                  den_i,
  input  side_t                                side_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic [QUO_BITS-1:0]                  quo_x_o,
  output logic [QUO_BITS-1:0]                  quo_y_o,
  output side_t                                side_o
);

  localparam int unsigned NW = FracBits + DEN_BITS;

  logic              v_q   [QUO_BITS];
  logic [NW-1:0]     rx_q  [QUO_BITS];
  logic [NW-1:0]     ry_q  [QUO_BITS];
  logic [DEN_BITS-1:0] d_q [QUO_BITS];
  logic [QUO_BITS-1:0] qx_q [QUO_BITS];
  logic [QUO_BITS-1:0] qy_q [QUO_BITS];
  side_t             s_q   [QUO_BITS];

  logic              si_v  [QUO_BITS];
  logic [NW-1:0]     si_rx [QUO_BITS];
  logic [NW-1:0]     si_ry [QUO_BITS];
  logic [DEN_BITS-1:0] si_d [QUO_BITS];
  logic [QUO_BITS-1:0] si_qx [QUO_BITS];
  logic [QUO_BITS-1:0] si_qy [QUO_BITS];
  side_t             si_s  [QUO_BITS];
  logic              rdy   [QUO_BITS];

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
    localparam int unsigned Sh = QUO_BITS - 1 - k;

    logic [NW-1:0]       dext;
    logic                fx;
    logic                fy;
    logic [NW-1:0]       rx_d;
    logic [NW-1:0]       ry_d;

    if (k == 0) begin : g_first
      assign si_v[k]  = valid_i;
      assign si_rx[k] = num_x_i;
      assign si_ry[k] = num_y_i;
      assign si_d[k]  = den_i;
      assign si_qx[k] = '0;
      assign si_qy[k] = '0;
      assign si_s[k]  = side_i;
    end else begin : g_next
      assign si_v[k]  = v_q[k-1];
      assign si_rx[k] = rx_q[k-1];
      assign si_ry[k] = ry_q[k-1];
      assign si_d[k]  = d_q[k-1];
      assign si_qx[k] = qx_q[k-1];
      assign si_qy[k] = qy_q[k-1];
      assign si_s[k]  = s_q[k-1];
    end

    if (k == QUO_BITS - 1) begin : g_last_rdy
      assign rdy[k] = !v_q[k] || ready_i;
    end else begin : g_mid_rdy
      assign rdy[k] = !v_q[k] || rdy[k+1];
    end

    always_comb begin
      dext = NW'(si_d[k]);
      fx   = (si_rx[k] >> Sh) >= dext;
      fy   = (si_ry[k] >> Sh) >= dext;
      rx_d = fx ? si_rx[k] - (dext << Sh) : si_rx[k];
      ry_d = fy ? si_ry[k] - (dext << Sh) : si_ry[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= si_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        rx_q[k] <= rx_d;
        ry_q[k] <= ry_d;
        d_q[k]  <= si_d[k];
        qx_q[k] <= {si_qx[k][QUO_BITS-2:0], fx};
        qy_q[k] <= {si_qy[k][QUO_BITS-2:0], fy};
        s_q[k]  <= si_s[k];
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[QUO_BITS-1];
  assign quo_x_o = qx_q[QUO_BITS-1];
  assign quo_y_o = qy_q[QUO_BITS-1];
  assign side_o  = s_q[QUO_BITS-1];

`ifndef SYNTHESIS
  a_stall_holds_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o) else $error("divider lost a stalled transaction");
  a_stall_holds_quo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> $stable(quo_x_o) && $stable(quo_y_o))
    else $error("divider quotient changed under stall");
  a_busy_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> v_q[0]) else $error("divider blocked with empty first stage");
`endif

endmodule

[sim/pinhole_reprojection_residual_tb.sv]
`timescale 1ns / 1ps

module pinhole_reprojection_residual_tb;
  import prr_pkg::*;

  typedef struct {
    func_e              func;
    logic [3:0]         word_index;
    logic signed [31:0] word_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] obs_x;
    logic signed [31:0] obs_y;
  } item_t;

  typedef struct {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic               invalid;
    logic               clip;
  } residual_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  prr_in_if  in_if ();
  prr_out_if out_if ();
  prr_cfg_if cfg_if ();

  pinhole_reprojection_residual DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  item_t     pending_items[$];
  residual_t expected_residuals[$];
  int        error_count = 0;

  logic [30:0]        focal_x_m, focal_y_m;
  logic signed [31:0] center_x_m, center_y_m;
  logic signed [31:0] pose_m[POSE_WORDS];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint clip32(input longint v, inout logic clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint round_q(input longint v);
    return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint divide_nearest(input longint num, input longint den);
    longint unsigned n, d, q;
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = (2 * n + d) / (2 * d);
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic residual_t project_point(input item_t it);
    residual_t r;
    longint pt[3], cam[3], acc, nrm, pred, obs[2], ctr[2], foc[2];
    logic clip;
    clip = 1'b0;
    pt[0] = it.point_x;
    pt[1] = it.point_y;
    pt[2] = it.point_z;
    obs[0] = it.obs_x;
    obs[1] = it.obs_y;
    foc[0] = focal_x_m;
    foc[1] = focal_y_m;
    ctr[0] = center_x_m;
    ctr[1] = center_y_m;
    for (int i = 0; i < 3; i++) begin
      acc = pose_m[9 + i];
      for (int j = 0; j < 3; j++) acc += round_q(longint'(pose_m[3 * i + j]) * pt[j]);
      cam[i] = clip32(acc, clip);
    end
    r.invalid = (cam[2] == 0);
    r.res_x = '0;
    r.res_y = '0;
    if (!r.invalid) begin
      for (int i = 0; i < 2; i++) begin
        nrm = clip32(divide_nearest(cam[i] <<< FRAC_BITS, cam[2]), clip);
        pred = round_q(foc[i] * nrm) + ctr[i];
        pred = clip32(pred - obs[i], clip);
        if (i == 0) r.res_x = pred[31:0];
        else r.res_y = pred[31:0];
      end
    end
    r.clip = clip;
    return r;
  endfunction

  int in_wait = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_wait <= 0;
    end else begin
      item_t it;
      if (in_if.valid && in_if.ready) begin
        it.func = func_e'(in_if.func);
        it.word_index = in_if.word_index;
        it.word_value = in_if.word_value;
        it.point_x = in_if.point_x;
        it.point_y = in_if.point_y;
        it.point_z = in_if.point_z;
        it.obs_x = in_if.pixel_obs_x;
        it.obs_y = in_if.pixel_obs_y;
        if (it.func == FUNC_LOAD) begin
          if (it.word_index < POSE_WORDS) pose_m[it.word_index] = it.word_value;
        end else begin
          expected_residuals = {expected_residuals, project_point(it)};
        end
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_wait > 0) begin
          in_wait <= in_wait - 1;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_if.valid <= 1'b1;
          in_if.func <= it.func;
          in_if.word_index <= it.word_index;
          in_if.word_value <= it.word_value;
          in_if.point_x <= it.point_x;
          in_if.point_y <= it.point_y;
          in_if.point_z <= it.point_z;
          in_if.pixel_obs_x <= it.obs_x;
          in_if.pixel_obs_y <= it.obs_y;
          in_wait <= (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3));
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  int out_wait = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_wait <= 0;
    end else begin
      residual_t exp_r;
      if (out_if.valid && out_if.ready) begin
        if (expected_residuals.size() == 0) begin
          $error("result without a pending projection");
          error_count++;
        end else begin
          exp_r = expected_residuals.pop_front();
          if (out_if.residual_x !== exp_r.res_x) begin
            $error("residual_x expected %0d actual %0d", exp_r.res_x, out_if.residual_x);
            error_count++;
          end
          if (out_if.residual_y !== exp_r.res_y) begin
            $error("residual_y expected %0d actual %0d", exp_r.res_y, out_if.residual_y);
            error_count++;
          end
          if (out_if.depth_invalid !== exp_r.invalid) begin
            $error("depth_invalid expected %0b actual %0b", exp_r.invalid,
                   out_if.depth_invalid);
            error_count++;
          end
          if (out_if.saturated !== exp_r.clip) begin
            $error("saturated expected %0b actual %0b", exp_r.clip, out_if.saturated);
            error_count++;
          end
        end
      end
      if (out_wait > 0) begin
        out_wait <= out_wait - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (out_if.valid) out_wait <= (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3));
      end
    end
  end

  initial begin
    in_if.func = FUNC_LOAD;
    in_if.word_index = '0;
    in_if.word_value = '0;
    in_if.point_x = '0;
    in_if.point_y = '0;
    in_if.point_z = '0;
    in_if.pixel_obs_x = '0;
    in_if.pixel_obs_y = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_FOCAL_X;
    cfg_if.data = '0;
    focal_x_m = 31'd65536;
    focal_y_m = 31'd65536;
    center_x_m = '0;
    center_y_m = '0;
    for (int i = 0; i < POSE_WORDS; i++) pose_m[i] = '0;
  end

  task automatic write_register(input cfg_reg_e idx, input logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_FOCAL_X:  focal_x_m = value[30:0];
      CFG_FOCAL_Y:  focal_y_m = value[30:0];
      CFG_CENTER_X: center_x_m = value;
      CFG_CENTER_Y: center_y_m = value;
      default: ;
    endcase
  endtask

  task automatic drain_pipeline();
    while (pending_items.size() > 0 || in_if.valid || expected_residuals.size() > 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word(input int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 4) << 16;
      2: return -($urandom_range(0, 4) << 16);
      default: return $signed($urandom_range(0, 262143)) - 131072;
    endcase
  endfunction

  task automatic add_load(input logic [3:0] idx, input logic [31:0] value);
    item_t it;
    it.func = FUNC_LOAD;
    it.word_index = idx;
    it.word_value = value;
    it.point_x = $urandom();
    it.point_y = '0;
    it.point_z = '0;
    it.obs_x = '0;
    it.obs_y = '0;
    pending_items = {pending_items, it};
  endtask

  task automatic add_project(input logic [31:0] x, y, z, ox, oy);
    item_t it;
    it.func = FUNC_PROJECT;
    it.word_index = 4'($urandom());
    it.word_value = $urandom();
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    it.obs_x = ox;
    it.obs_y = oy;
    pending_items = {pending_items, it};
  endtask

  task automatic load_random_pose(input int mode);
    for (int w = 0; w < POSE_WORDS; w++) begin
      if (w == 0 || w == 4 || w == 8)
        add_load(4'(w), (mode == 3) ? 32'h0001_0000 : rand_word(mode));
      else if (w == 11) add_load(4'(w), $urandom_range(1, 20) << 16);
      else add_load(4'(w), rand_word(mode));
    end
  endtask

  initial begin
    logic [31:0] cfg_values[4];
    int mode;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: identity pose, zero depth, out-of-range slots and extreme values.
    add_project(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
    add_load(0, 32'h0001_0000);
    add_load(4, 32'h0001_0000);
    add_load(8, 32'h0001_0000);
    add_load(12, 32'h7FFF_FFFF);
    add_load(15, 32'h8000_0000);
    add_project(32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF);
    add_project(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
    add_project(32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0);
    add_project(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    add_load(9, 32'h7FFF_FFFF);
    add_load(1, 32'h7FFF_FFFF);
    add_project(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0003_0000, 32'h0, 32'h0);
    add_load(9, 32'h8000_0000);
    add_load(1, 32'h8000_0000);
    add_project(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0003_0000, 32'hFFFF_FFFF, 32'h1);
    add_load(11, 32'hFFFF_0000);
    add_project(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
    add_project(32'h0, 32'h0, 32'h0001_8000, 32'h5555_5555, 32'hAAAA_AAAA);
    drain_pipeline();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: cfg_values = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        1: cfg_values = '{32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF};
        2: cfg_values = '{32'hFFFF_FFFF, 32'h0001_0000, 32'h0, 32'h0};
        default: cfg_values = '{$urandom_range(0, 2000) << 16, $urandom_range(0, 2000) << 16,
                                $urandom(), $urandom()};
      endcase
      write_register(CFG_FOCAL_X, cfg_values[0]);
      write_register(CFG_FOCAL_Y, cfg_values[1]);
      write_register(CFG_CENTER_X, cfg_values[2]);
      write_register(CFG_CENTER_Y, cfg_values[3]);
      cfg_if.valid <= 1'b0;
      for (int n = 0; n < 14; n++) begin
        mode = $urandom_range(0, 3);
        if ($urandom_range(0, 9) == 0) add_load(4'($urandom_range(0, 15)), $urandom());
        else load_random_pose(mode);
        for (int k = 0; k < 3; k++) begin
          if ($urandom_range(0, 4) == 0)
            add_project($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
          else
            add_project(rand_word(mode), rand_word(mode), $urandom_range(1, 40) << 16,
                        $urandom(), rand_word(3));
        end
      end
      drain_pipeline();
    end

    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[pinhole_reprojection_residual.f]
hw/rtl/prr_pkg.sv
hw/rtl/prr_if.sv
hw/rtl/prr_div.sv
hw/rtl/pinhole_reprojection_residual.sv
sim/pinhole_reprojection_residual_tb.sv
